// ===== hw/rtl/hangar_door_flow_sequencer_defines.svh =====
// ---------------------------------------------------------------------------
// Hangar door flow sequencer assertion macros
// Concurrent check wrappers; compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef HANGAR_DOOR_FLOW_SEQUENCER_DEFINES_SVH
`define HANGAR_DOOR_FLOW_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define HDFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HDFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HDFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define HDFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/hdfs_pkg.sv =====
// ---------------------------------------------------------------------------
// Hangar door flow sequencer package
// Flow states, command codes, register map and configuration bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package hdfs_pkg;

  // Flow states as reported on the result channel.
  typedef enum logic [2:0] {
    ST_INSIDE  = 3'd0,
    ST_TAKEOFF = 3'd1,
    ST_OUT     = 3'd2,
    ST_LANDING = 3'd3,
    ST_FORCED  = 3'd4
  } flow_state_e;

  // User command codes; the first code means no command.
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_TAKEOFF = 2'd1,
    CMD_LANDING = 2'd2,
    CMD_UNUSED  = 2'd3
  } user_cmd_e;

  // Configuration register map.
  typedef enum logic [1:0] {
    REG_FAR_THRESHOLD  = 2'd0,
    REG_NEAR_THRESHOLD = 2'd1,
    REG_OUT_DWELL      = 2'd2,
    REG_IN_DWELL       = 2'd3
  } cfg_reg_e;

  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned DWELL_W    = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [THRESH_W-1:0] FAR_THRESHOLD_RST  = 16'd1000;
  localparam logic [THRESH_W-1:0] NEAR_THRESHOLD_RST = 16'd200;
  localparam logic [DWELL_W-1:0]  OUT_DWELL_RST      = 32'd3000;
  localparam logic [DWELL_W-1:0]  IN_DWELL_RST       = 32'd3000;

  typedef struct packed {
    logic [THRESH_W-1:0] far_threshold_mm;
    logic [THRESH_W-1:0] near_threshold_mm;
    logic [DWELL_W-1:0]  out_dwell_ms;
    logic [DWELL_W-1:0]  in_dwell_ms;
  } hdfs_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hdfs_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Hangar door flow sequencer configuration registers
// Write-only threshold and dwell registers with their reset values.
// ---------------------------------------------------------------------------
`default_nettype none

module hdfs_cfg_regs (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [hdfs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [hdfs_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output hdfs_pkg::hdfs_cfg_t                        cfg_o
);

  hdfs_pkg::hdfs_cfg_t cfg_q;
  hdfs_pkg::hdfs_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (hdfs_pkg::cfg_reg_e'(cfg_idx_i))
        hdfs_pkg::REG_FAR_THRESHOLD: begin
          cfg_d.far_threshold_mm = cfg_data_i[hdfs_pkg::THRESH_W-1:0];
        end
        hdfs_pkg::REG_NEAR_THRESHOLD: begin
          cfg_d.near_threshold_mm = cfg_data_i[hdfs_pkg::THRESH_W-1:0];
        end
        hdfs_pkg::REG_OUT_DWELL: begin
          cfg_d.out_dwell_ms = cfg_data_i[hdfs_pkg::DWELL_W-1:0];
        end
        hdfs_pkg::REG_IN_DWELL: begin
          cfg_d.in_dwell_ms = cfg_data_i[hdfs_pkg::DWELL_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.far_threshold_mm  <= hdfs_pkg::FAR_THRESHOLD_RST;
      cfg_q.near_threshold_mm <= hdfs_pkg::NEAR_THRESHOLD_RST;
      cfg_q.out_dwell_ms      <= hdfs_pkg::OUT_DWELL_RST;
      cfg_q.in_dwell_ms       <= hdfs_pkg::IN_DWELL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hdfs_step.sv =====
// ---------------------------------------------------------------------------
// Hangar door flow sequencer step logic
// Next flow state, dwell flag and dwell stamp for one task tick.
// ---------------------------------------------------------------------------
`default_nettype none

module hdfs_step #(
  parameter int unsigned DIST_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire hdfs_pkg::flow_state_e   state_i,
  input  wire logic                    armed_i,
  input  wire logic [TIME_BITS-1:0]    start_i,
  input  wire hdfs_pkg::hdfs_cfg_t     cfg_i,
  input  wire logic                    drone_present_i,
  input  wire logic                    alarm_active_i,
  input  wire logic [1:0]              user_command_i,
  input  wire logic [DIST_BITS-1:0]    distance_mm_i,
  input  wire logic [TIME_BITS-1:0]    now_ms_i,
  output hdfs_pkg::flow_state_e        state_o,
  output logic                         armed_o,
  output logic [TIME_BITS-1:0]         start_o
);

  logic [31:0]          far_ext;
  logic [31:0]          near_ext;
  logic [DIST_BITS-1:0] far_t;
  logic [DIST_BITS-1:0] near_t;
  logic [TIME_BITS-1:0] out_dwell;
  logic [TIME_BITS-1:0] in_dwell;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] dwell_sel;
  logic                 is_far;
  logic                 is_near;
  logic                 qual_on;
  logic                 cond;
  hdfs_pkg::flow_state_e done_state;
  hdfs_pkg::user_cmd_e   cmd;

  assign far_ext   = 32'(cfg_i.far_threshold_mm);
  assign near_ext  = 32'(cfg_i.near_threshold_mm);
  assign far_t     = far_ext[DIST_BITS-1:0];
  assign near_t    = near_ext[DIST_BITS-1:0];
  assign out_dwell = cfg_i.out_dwell_ms[TIME_BITS-1:0];
  assign in_dwell  = cfg_i.in_dwell_ms[TIME_BITS-1:0];
  assign elapsed   = now_ms_i - start_i;
  assign is_far    = distance_mm_i > far_t;
  assign is_near   = distance_mm_i < near_t;
  assign cmd       = hdfs_pkg::user_cmd_e'(user_command_i);

  always_comb begin
    state_o    = state_i;
    armed_o    = armed_i;
    start_o    = start_i;
    qual_on    = 1'b0;
    cond       = 1'b0;
    dwell_sel  = out_dwell;
    done_state = hdfs_pkg::ST_OUT;

    case (state_i)
      hdfs_pkg::ST_INSIDE: begin
        if (drone_present_i && !alarm_active_i && (cmd == hdfs_pkg::CMD_TAKEOFF)) begin
          state_o = hdfs_pkg::ST_TAKEOFF;
        end
      end
      hdfs_pkg::ST_TAKEOFF: begin
        if (alarm_active_i) begin
          state_o = hdfs_pkg::ST_FORCED;
        end
        qual_on = 1'b1;
        cond    = is_far;
      end
      hdfs_pkg::ST_OUT: begin
        if (cmd == hdfs_pkg::CMD_LANDING) begin
          state_o = hdfs_pkg::ST_LANDING;
        end
      end
      hdfs_pkg::ST_LANDING: begin
        if (alarm_active_i) begin
          state_o = hdfs_pkg::ST_FORCED;
        end
        qual_on    = 1'b1;
        cond       = is_near;
        dwell_sel  = in_dwell;
        done_state = hdfs_pkg::ST_INSIDE;
      end
      hdfs_pkg::ST_FORCED: begin
        qual_on = 1'b1;
        if (is_far) begin
          cond = 1'b1;
        end else if (is_near) begin
          cond       = 1'b1;
          dwell_sel  = in_dwell;
          done_state = hdfs_pkg::ST_INSIDE;
        end
      end
      default: begin
        qual_on = 1'b0;
      end
    endcase

    // Shared dwell qualifier: arm stamps, completion overrides any alarm choice.
    if (qual_on) begin
      if (!cond) begin
        armed_o = 1'b1;
      end else if (armed_i) begin
        start_o = now_ms_i;
        armed_o = 1'b0;
      end else if (elapsed > dwell_sel) begin
        armed_o = 1'b1;
        state_o = done_state;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hangar_door_flow_sequencer.sv =====
// ---------------------------------------------------------------------------
// Hangar door flow sequencer
// Five-state drone hangar flow control, one task tick per request.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                       Payload
//  --------  ------------------------------  ---------------------------------
//  tick in   in_valid_i / in_ready_o         drone_present, alarm_active,
//                                            user_command, distance_mm, now_ms
//  state out out_valid_o / out_ready_i       flow_state
//  config    cfg_we_i (no wait)              cfg_idx_i, cfg_data_i
//
//  Each request is held in the input register, then its next state is
//  computed and written to the state and result registers; one request per
//  cycle is sustained while the consumer keeps taking results.
//  The input register frees up in the same cycle the result register drains,
//  so one request can wait while a result is held by a stalled consumer.
//  Reset clears the flow state to inside, arms the dwell timer, zeroes its
//  stamp and loads the default thresholds and dwell times. No clearing pass.
//
`default_nettype none

module hangar_door_flow_sequencer #(
  parameter int unsigned DIST_BITS = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tick requests
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              drone_present_i,
  input  wire logic                              alarm_active_i,
  input  wire logic [1:0]                        user_command_i,
  input  wire logic [DIST_BITS-1:0]              distance_mm_i,
  input  wire logic [TIME_BITS-1:0]              now_ms_i,
  // state results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [2:0]                             flow_state_o,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [hdfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [hdfs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

`include "hangar_door_flow_sequencer_defines.svh"

  hdfs_pkg::hdfs_cfg_t cfg;

  // Input register
  logic                 in_valid_q;
  logic                 present_q;
  logic                 alarm_q;
  logic [1:0]           cmd_q;
  logic [DIST_BITS-1:0] dist_q;
  logic [TIME_BITS-1:0] now_q;

  // Sequencer state
  hdfs_pkg::flow_state_e state_q;
  hdfs_pkg::flow_state_e state_d;
  logic                  armed_q;
  logic                  armed_d;
  logic [TIME_BITS-1:0]  start_q;
  logic [TIME_BITS-1:0]  start_d;

  // Result register
  logic       out_valid_q;
  logic [2:0] flow_state_q;

  logic fire;
  logic in_take;

  hdfs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hdfs_step #(
    .DIST_BITS (DIST_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .state_i         (state_q),
    .armed_i         (armed_q),
    .start_i         (start_q),
    .cfg_i           (cfg),
    .drone_present_i (present_q),
    .alarm_active_i  (alarm_q),
    .user_command_i  (cmd_q),
    .distance_mm_i   (dist_q),
    .now_ms_i        (now_q),
    .state_o         (state_d),
    .armed_o         (armed_d),
    .start_o         (start_d)
  );

  // Advance a held request when the result slot is empty or draining.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; load on accept only.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      present_q <= drone_present_i;
      alarm_q   <= alarm_active_i;
      cmd_q     <= user_command_i;
      dist_q    <= distance_mm_i;
      now_q     <= now_ms_i;
    end
  end

  // Commit the step only when its result can be stored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hdfs_pkg::ST_INSIDE;
      armed_q <= 1'b1;
      start_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
      armed_q <= armed_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      flow_state_q <= state_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign flow_state_o = flow_state_q;

  // The input side only stalls behind a full, stalled result slot.
  `HDFS_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, !in_ready_o,
    in_valid_q && out_valid_q && !out_ready_i, "input stalled without a held result")

  // State moves only when a request is committed.
  `HDFS_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !fire, $stable(state_q),
    "flow state changed without a request")

  // A committed request shows its new state on the result channel.
  `HDFS_ASSERT_NEXT(a_result_match, clk_i, rst_ni, fire,
    out_valid_q && (flow_state_q == state_q), "result does not match committed state")

  // The dwell timer is only ever running in take-off, landing or forced closing.
  `HDFS_ASSERT_SAME(a_armed_states, clk_i, rst_ni, !armed_q,
    (state_q == hdfs_pkg::ST_TAKEOFF) || (state_q == hdfs_pkg::ST_LANDING) ||
    (state_q == hdfs_pkg::ST_FORCED), "dwell timer running while parked")

endmodule

`default_nettype wire
